@@ rtl/mm9_pkg.sv @@
// ----------------------------------------------------------------------------
// mm9_pkg
// Shared types and constants of the 9x29 Montgomery multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package mm9_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 58;

    localparam logic [CFG_IDX_W-1:0] REG_MOD_01  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_23  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_45  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_67  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_8   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NEG_INV = 3'd5;

    // Number of modulus limbs the register file can hold.
    localparam int MOD_LIMBS    = 9;
    localparam int MOD_PAIR_REGS = 4;
    localparam int CFG_NARROW_W = 29;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_AB,
        OP_M,
        OP_MP
    } mop_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_AB,
        ST_M,
        ST_MWAIT,
        ST_MP,
        ST_DRAIN,
        ST_SUB,
        ST_OUT
    } state_t;

    typedef struct packed {
        mop_t op;
        logic in_wr;
        logic acc_clr;
        logic sub_en;
        logic out_load;
    } dp_cmd_t;

endpackage

`default_nettype wire

@@ rtl/mm9_ctrl.sv @@
// ----------------------------------------------------------------------------
// mm9_ctrl
// Sequencer for limb loading, CIOS rows, final subtraction and result output.
// ----------------------------------------------------------------------------
`default_nettype none

module mm9_ctrl #(
    parameter int NUM_LIMBS = 9
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output mm9_pkg::dp_cmd_t                    cmd,
    output logic [$clog2(NUM_LIMBS)-1:0]        idx,
    output logic [$clog2(NUM_LIMBS)-1:0]        row
);
    import mm9_pkg::*;

    localparam int IW = $clog2(NUM_LIMBS);
    localparam int CW = $clog2(NUM_LIMBS + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(NUM_LIMBS - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(NUM_LIMBS);
    localparam logic [IW-1:0] LAST_ROW = IW'(NUM_LIMBS - 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] row_reg, row_next;
    logic          m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            row_reg     <= row_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        row_next     = row_reg;
        m_valid_next = m_valid_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (cnt_reg == LAST_CNT) begin
                        state_next = ST_AB;
                        cnt_next   = '0;
                        row_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_AB: begin
                if (cnt_reg == LAST_CNT) begin
                    state_next = ST_M;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_M: begin
                state_next = ST_MWAIT;
            end
            ST_MWAIT: begin
                state_next = ST_MP;
            end
            ST_MP: begin
                if (cnt_reg == LAST_CNT) begin
                    cnt_next = '0;
                    if (row_reg == LAST_ROW) begin
                        state_next = ST_DRAIN;
                    end else begin
                        state_next = ST_AB;
                        row_next   = row_reg + 1'b1;
                    end
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_SUB;
            end
            ST_SUB: begin
                if (cnt_reg == LAST_CNT) begin
                    state_next = ST_OUT;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    if (cnt_reg == FULL_CNT) begin
                        m_valid_next = 1'b0;
                        state_next   = ST_LOAD;
                        cnt_next     = '0;
                    end else begin
                        m_valid_next = 1'b1;
                        cnt_next     = cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.op       = OP_NONE;
        s_ready      = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready     = 1'b1;
                cmd.in_wr   = s_valid;
                cmd.acc_clr = s_valid && (cnt_reg == LAST_CNT);
            end
            ST_AB: begin
                cmd.op = OP_AB;
            end
            ST_M: begin
                cmd.op = OP_M;
            end
            ST_MP: begin
                cmd.op = OP_MP;
            end
            ST_SUB: begin
                cmd.sub_en = 1'b1;
            end
            ST_OUT: begin
                cmd.out_load = (cnt_reg != FULL_CNT) && (!m_valid_reg || m_ready);
            end
            default: begin
                cmd.op = OP_NONE;
            end
        endcase
    end

    assign idx     = cnt_reg[IW-1:0];
    assign row     = row_reg;
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

@@ rtl/mm9_dp.sv @@
// ----------------------------------------------------------------------------
// mm9_dp
// Operand stores, modulus registers, shared multiplier and accumulator row.
// ----------------------------------------------------------------------------
`default_nettype none

module mm9_dp #(
    parameter int NUM_LIMBS = 9,
    parameter int LIMB_BITS = 29
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire mm9_pkg::dp_cmd_t                  cmd,
    input  wire logic [$clog2(NUM_LIMBS)-1:0]      idx,
    input  wire logic [$clog2(NUM_LIMBS)-1:0]      row,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mm9_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mm9_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  wire logic [LIMB_BITS-1:0]              s_a_limb,
    input  wire logic [LIMB_BITS-1:0]              s_b_limb,
    output logic [LIMB_BITS-1:0]                   m_result_limb,
    output logic                                   m_last_limb
);
    import mm9_pkg::*;

    localparam int IW     = $clog2(NUM_LIMBS);
    localparam int PROD_W = 2 * LIMB_BITS;
    localparam int ACC_W  = 2 * LIMB_BITS + 2;
    localparam int CAR_W  = ACC_W - LIMB_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_LIMBS - 1);

    logic [CFG_DATA_W-1:0]   mod_reg [MOD_PAIR_REGS];
    logic [CFG_NARROW_W-1:0] mod_top_reg;
    logic [CFG_NARROW_W-1:0] inv_reg;
    logic [LIMB_BITS-1:0]    p_limb [NUM_LIMBS];

    logic [LIMB_BITS-1:0]    a_store_reg [NUM_LIMBS];
    logic [LIMB_BITS-1:0]    b_store_reg [NUM_LIMBS];
    logic [ACC_W-1:0]        acc_reg [NUM_LIMBS];
    logic [LIMB_BITS-1:0]    diff_reg [NUM_LIMBS];
    logic [LIMB_BITS-1:0]    m_reg;
    logic [CAR_W-1:0]        carry_reg;
    logic                    borrow_reg;

    mop_t                    op_s1_reg;
    logic [IW-1:0]           idx_s1_reg;
    logic [PROD_W-1:0]       prod_reg;

    logic [LIMB_BITS-1:0]    m_result_limb_reg;
    logic                    m_last_limb_reg;

    logic [LIMB_BITS-1:0]    mul_x;
    logic [LIMB_BITS-1:0]    mul_y;
    logic [PROD_W-1:0]       prod_next;
    logic [IW-1:0]           rd_addr;
    logic [ACC_W-1:0]        acc_rd;
    logic [ACC_W-1:0]        add_in;
    logic [ACC_W-1:0]        sum;
    logic [ACC_W-1:0]        sub_val;
    logic [ACC_W-1:0]        diff_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MOD_PAIR_REGS; k++) begin
                mod_reg[k] <= '0;
            end
            mod_top_reg <= '0;
            inv_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MOD_01:  mod_reg[0]  <= cfg_wr_data;
                REG_MOD_23:  mod_reg[1]  <= cfg_wr_data;
                REG_MOD_45:  mod_reg[2]  <= cfg_wr_data;
                REG_MOD_67:  mod_reg[3]  <= cfg_wr_data;
                REG_MOD_8:   mod_top_reg <= cfg_wr_data[CFG_NARROW_W-1:0];
                REG_NEG_INV: inv_reg     <= cfg_wr_data[CFG_NARROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Modulus limbs above the register file read as zero.
    for (genvar j = 0; j < NUM_LIMBS; j++) begin : g_plimb
        if (j == MOD_LIMBS - 1) begin : g_top
            assign p_limb[j] = mod_top_reg[LIMB_BITS-1:0];
        end else if (j < MOD_LIMBS - 1) begin : g_pair
            if ((j % 2) == 1) begin : g_odd
                assign p_limb[j] = mod_reg[j/2][LIMB_BITS +: LIMB_BITS];
            end else begin : g_even
                assign p_limb[j] = mod_reg[j/2][LIMB_BITS-1:0];
            end
        end else begin : g_zero
            assign p_limb[j] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_wr) begin
            a_store_reg[idx] <= s_a_limb;
            b_store_reg[idx] <= s_b_limb;
        end
    end

    always_comb begin
        case (cmd.op)
            OP_AB: begin
                mul_x = a_store_reg[idx];
                mul_y = b_store_reg[row];
            end
            OP_M: begin
                mul_x = acc_reg[0][LIMB_BITS-1:0];
                mul_y = inv_reg[LIMB_BITS-1:0];
            end
            OP_MP: begin
                mul_x = m_reg;
                mul_y = p_limb[idx];
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign prod_next = mul_x * mul_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_s1_reg <= OP_NONE;
        end else begin
            op_s1_reg <= cmd.op;
        end
    end

    always_ff @(posedge aclk) begin
        idx_s1_reg <= idx;
        prod_reg   <= prod_next;
    end

    assign rd_addr = (op_s1_reg != OP_NONE) ? idx_s1_reg : idx;
    assign acc_rd  = acc_reg[rd_addr];
    assign add_in  = (op_s1_reg == OP_MP && idx_s1_reg != '0) ? ACC_W'(carry_reg) : '0;
    assign sum     = acc_rd + ACC_W'(prod_reg) + add_in;

    assign sub_val   = ACC_W'(p_limb[idx]) + ACC_W'((idx != '0) && borrow_reg);
    assign diff_full = acc_rd - sub_val;

    // Normalization and the one-limb shift share the write of each row pass.
    always_ff @(posedge aclk) begin
        if (cmd.acc_clr) begin
            for (int k = 0; k < NUM_LIMBS; k++) begin
                acc_reg[k] <= '0;
            end
        end else begin
            case (op_s1_reg)
                OP_AB: begin
                    acc_reg[idx_s1_reg] <= sum;
                end
                OP_M: begin
                    m_reg <= prod_reg[LIMB_BITS-1:0];
                end
                OP_MP: begin
                    carry_reg <= sum[ACC_W-1:LIMB_BITS];
                    if (idx_s1_reg != '0) begin
                        acc_reg[IW'(idx_s1_reg - 1'b1)] <= ACC_W'(sum[LIMB_BITS-1:0]);
                    end
                    if (idx_s1_reg == LAST_IDX) begin
                        acc_reg[LAST_IDX] <= ACC_W'(sum[ACC_W-1:LIMB_BITS]);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sub_en) begin
            diff_reg[idx] <= diff_full[LIMB_BITS-1:0];
            borrow_reg    <= (acc_rd < sub_val);
        end
        if (cmd.out_load) begin
            m_result_limb_reg <= borrow_reg ? acc_rd[LIMB_BITS-1:0] : diff_reg[idx];
            m_last_limb_reg   <= (idx == LAST_IDX);
        end
    end

    assign m_result_limb = m_result_limb_reg;
    assign m_last_limb   = m_last_limb_reg;

endmodule

`default_nettype wire

@@ rtl/montgomery_mult_9x29.sv @@
// ----------------------------------------------------------------------------
// montgomery_mult_9x29
// Montgomery multiplier a*b*R^-1 mod p over limbs, one shared limb multiplier.
// ----------------------------------------------------------------------------
//  Port group   Direction  Word
//  s_*          in         one limb of a and the same-index limb of b
//  m_*          out        one result limb, least significant first
//  cfg_*        in         modulus and negative inverse registers
//
//  A product takes a load phase, one row pass per limb (a*b limbs, m, a wait
//  step, then m*p limbs), a drain step, the final subtraction and the output
//  phase. All products go through the single registered limb multiplier.
//  Reset is synchronous and active low; no clearing pass is needed.
//  Input words are taken only while loading; output stalls hold the block.
// ----------------------------------------------------------------------------
`default_nettype none

module montgomery_mult_9x29 #(
    parameter int NUM_LIMBS = 9,
    parameter int LIMB_BITS = 29
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [LIMB_BITS-1:0]             s_a_limb,
    input  wire logic [LIMB_BITS-1:0]             s_b_limb,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [LIMB_BITS-1:0]                  m_result_limb,
    output logic                                  m_last_limb,
    input  wire logic                             cfg_wr_en,
    input  wire logic [mm9_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mm9_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import mm9_pkg::*;

    localparam int IW = $clog2(NUM_LIMBS);

    dp_cmd_t       cmd;
    logic [IW-1:0] idx;
    logic [IW-1:0] row;

    mm9_ctrl #(
        .NUM_LIMBS(NUM_LIMBS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .idx     (idx),
        .row     (row)
    );

    mm9_dp #(
        .NUM_LIMBS(NUM_LIMBS),
        .LIMB_BITS(LIMB_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .idx           (idx),
        .row           (row),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_a_limb      (s_a_limb),
        .s_b_limb      (s_b_limb),
        .m_result_limb (m_result_limb),
        .m_last_limb   (m_last_limb)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input taken while a result word is pending");

    a_last_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_limb |=> s_ready && !m_valid)
        else $error("block did not return to loading after the last word");

    a_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !m_last_limb)
        else $error("first result word marked as last");

    a_load_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid)
        else $error("result word appeared right after an input word");

endmodule

`default_nettype wire

@@ sim/montgomery_mult_9x29_tb.sv @@
// ----------------------------------------------------------------------------
// montgomery_mult_9x29_tb
// Self-checking testbench of the 9x29 Montgomery multiplier. Limb pairs are
// streamed in under random idling and back-pressure, and every result word
// is compared with a product computed inside the testbench. The modulus and
// inverse registers are changed between phases, extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import mm9_pkg::*;

typedef struct {
    logic [28:0] limb;
    logic        last;
} limb_word_t;

class product_scoreboard;
    logic [57:0] regs [6];
    logic [28:0] a_limbs [9];
    logic [28:0] b_limbs [9];
    int          loaded;
    limb_word_t  pending [$];
    int          errors;
    int          products;
    int          words_checked;

    function new();
        foreach (regs[i]) regs[i] = '0;
        loaded = 0;
        errors = 0;
        products = 0;
        words_checked = 0;
    endfunction

    function void write_reg(int idx, logic [57:0] value);
        if (idx < MOD_PAIR_REGS) regs[idx] = value;
        else if (idx < 6) regs[idx] = {29'd0, value[28:0]};
    endfunction

    function logic [28:0] mod_limb(int idx);
        logic [57:0] r;
        r = regs[idx >> 1];
        return (idx & 1) ? r[57:29] : r[28:0];
    endfunction

    function void compute_product();
        logic [63:0] acc [10];
        logic [63:0] p [9];
        logic [63:0] diff [9];
        logic [63:0] m, carry, inv, sub;
        limb_word_t  w;
        int          borrow;
        for (int j = 0; j < 9; j++) p[j] = {35'd0, mod_limb(j)};
        inv = {35'd0, regs[5][28:0]};
        foreach (acc[j]) acc[j] = '0;
        for (int i = 0; i < 9; i++) begin
            carry = '0;
            for (int j = 0; j < 9; j++) acc[j] += {35'd0, a_limbs[j]} * {35'd0, b_limbs[i]};
            m = ({35'd0, acc[0][28:0]} * inv) & 64'h1FFFFFFF;
            for (int j = 0; j < 9; j++) acc[j] += m * p[j];
            for (int j = 0; j < 9; j++) begin
                acc[j] += carry;
                carry = acc[j] >> 29;
                acc[j] &= 64'h1FFFFFFF;
            end
            acc[9] += carry;
            for (int j = 0; j < 9; j++) acc[j] = acc[j + 1];
            acc[9] = '0;
        end
        borrow = 0;
        for (int j = 0; j < 9; j++) begin
            sub = p[j] + borrow;
            if (acc[j] >= sub) begin
                diff[j] = acc[j] - sub;
                borrow = 0;
            end else begin
                diff[j] = acc[j] + (64'd1 << 29) - sub;
                borrow = 1;
            end
        end
        for (int j = 0; j < 9; j++) begin
            w.limb = borrow ? acc[j][28:0] : diff[j][28:0];
            w.last = (j == 8);
            pending.push_back(w);
        end
        products++;
    endfunction

    function void note_input(logic [28:0] a, logic [28:0] b);
        a_limbs[loaded] = a;
        b_limbs[loaded] = b;
        loaded++;
        if (loaded == 9) begin
            loaded = 0;
            compute_product();
        end
    endfunction

    function void check_result(logic [28:0] limb, logic last);
        limb_word_t w;
        if (pending.size() == 0) begin
            $display("%0t: unexpected word, actual limb %h last %b", $time, limb, last);
            errors++;
            return;
        end
        w = pending.pop_front();
        words_checked++;
        if (limb !== w.limb) begin
            $display("%0t: limb mismatch, expected %h, actual %h", $time, w.limb, limb);
            errors++;
        end
        if (last !== w.last) begin
            $display("%0t: last mismatch, expected %b, actual %b", $time, w.last, last);
            errors++;
        end
    endfunction
endclass

module montgomery_mult_9x29_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 288;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [28:0] s_a_limb = '0;
    logic [28:0] s_b_limb = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [28:0] m_result_limb;
    logic        m_last_limb;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    product_scoreboard sb = new();
    bit long_hold = 0;
    int idle_cycles = 0;

    always #2 aclk = ~aclk;

    montgomery_mult_9x29 dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_limb(s_a_limb), .s_b_limb(s_b_limb),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_limb(m_result_limb), .m_last_limb(m_last_limb),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [28:0] rand_limb();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return 29'($urandom());
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [57:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        sb.write_reg(int'(idx), value);
    endtask

    // Computes -p0^-1 mod 2^29 by Newton iteration; valid for an odd limb 0.
    function automatic logic [28:0] neg_inverse(logic [28:0] p0);
        logic [28:0] x;
        x = p0;
        for (int k = 0; k < 5; k++) x = x * (29'd2 - p0 * x);
        return -x;
    endfunction

    task automatic load_modulus(logic [28:0] limbs [9], bit good_inverse);
        write_reg(REG_MOD_01, {limbs[1], limbs[0]});
        write_reg(REG_MOD_23, {limbs[3], limbs[2]});
        write_reg(REG_MOD_45, {limbs[5], limbs[4]});
        write_reg(REG_MOD_67, {limbs[7], limbs[6]});
        write_reg(REG_MOD_8,  {29'($urandom()), limbs[8]});
        write_reg(REG_NEG_INV, good_inverse ? {29'd0, neg_inverse(limbs[0])}
                                            : {29'($urandom()), 29'($urandom())});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_limbs(logic [28:0] a, logic [28:0] b, bit idle);
        int g;
        g = idle ? gap_length() : 0;
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_a_limb <= a;
        s_b_limb <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(a, b);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_result_limb, m_last_limb);
    end

    always @(posedge aclk) begin
        if (long_hold) m_ready <= 1'b0;
        else if ($urandom_range(0, 3) == 0) m_ready <= 1'b0;
        else m_ready <= 1'b1;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [28:0] mod [9];
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: all-ones odd modulus, extreme operands.
        foreach (mod[j]) mod[j] = '1;
        load_modulus(mod, 1);
        for (int j = 0; j < 9; j++) send_limbs('1, '1, 0);
        for (int j = 0; j < 9; j++) send_limbs('0, '1, 1);
        for (int j = 0; j < 9; j++) send_limbs(j == 0 ? 29'd1 : '0, '1, 1);
        s_valid <= 1'b0;
        wait_drained();

        // Zero modulus and random inverse.
        foreach (mod[j]) mod[j] = '0;
        load_modulus(mod, 0);
        for (int j = 0; j < 9; j++) send_limbs('1, '1, 1);
        s_valid <= 1'b0;
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            foreach (mod[j]) mod[j] = rand_limb();
            mod[0][0] = 1'b1;
            if (phase == 2) mod[8] = 29'd1;
            load_modulus(mod, phase != 3);
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                if (phase == 1 && n == 20) begin
                    fork
                        begin
                            long_hold = 1;
                            repeat (400) @(posedge aclk);
                            long_hold = 0;
                        end
                    join_none
                end
                // Top limb of b kept small in the first two phases, mostly below the modulus.
                send_limbs(rand_limb(), (n % 9 == 8 && phase < 2) ? 29'($urandom_range(0, 7))
                                                                 : rand_limb(), 1);
            end
            s_valid <= 1'b0;
            wait fork;
            wait_drained();
        end

        $display("Covered %0d products, %0d result words, four moduli plus extreme settings.",
                 sb.products, sb.words_checked);
        if (sb.errors == 0 && sb.pending.size() == 0 && sb.loaded == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
